FILE: hw/rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// shared types and codes of the message ring fifo: request modes, result
// kinds and the command beat passed from the front end to the back end
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

   localparam int MODE_W  = 3;
   localparam int KIND_W  = 3;
   localparam int DATA_W  = 8;
   localparam int HLEN_W  = 7;
   localparam int COUNT_W = 6;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STORED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd4;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_STATUS  = 3'd4
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] data;
      logic              last;
   } cmd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/message_ring_fifo.sv
// a request beat is registered in the command queue before the executor pops it; a commit or
//   status or empty beat is set in the rsp register in ST_EXEC, a read byte in ST_STREAM
// throughput: plain byte writes and clears retire one per cycle while the executor is idle;
//   a read streams one byte per cycle off the byte ram port unless rsp stalls
// reset: synchronous, active high; empties the ring and the command queue, ram contents stay
// ----------------------------------------------------------------------------
// message_ring_fifo
// ring of message slots with a length table; byte writes commit on the
// last byte, dequeue and peek stream the head message back out
// ----------------------------------------------------------------------------
`default_nettype none

module message_ring_fifo #(
   parameter int SLOTS   = 8,
   parameter int MAX_LEN = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mrf_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [mrf_pkg::DATA_W-1:0]   req_data_in,
   input  wire logic                         req_last_in,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [mrf_pkg::KIND_W-1:0]        rsp_kind,
   output logic [mrf_pkg::DATA_W-1:0]        rsp_data_out,
   output logic                              rsp_last_out,
   output logic [mrf_pkg::HLEN_W-1:0]        rsp_head_length,
   output logic [mrf_pkg::COUNT_W-1:0]       rsp_stored_count,
   output logic                              rsp_truncated
);

   import mrf_pkg::*;

   // front end to queue
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   // queue to back end
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // decode the request beat into a command, drop unknown modes
   mrf_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_data_in (req_data_in),
      .req_last_in (req_last_in),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   // short queue so the request side keeps moving while a message streams out
   mrf_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // executor: ring pointers, byte and length rams, response register
   mrf_back #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_cmd          (pop_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_out     (rsp_last_out),
      .rsp_head_length  (rsp_head_length),
      .rsp_stored_count (rsp_stored_count),
      .rsp_truncated    (rsp_truncated)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_ram.sv
// ----------------------------------------------------------------------------
// mrf_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// request decoder: turns a request beat into a command for the queue,
// unknown modes are taken and dropped
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_front (
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [mrf_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [mrf_pkg::DATA_W-1:0]  req_data_in,
   input  wire logic                        req_last_in,
   output logic                             push_valid,
   input  wire logic                        push_ready,
   output mrf_pkg::cmd_type                 push_cmd
);

   import mrf_pkg::*;

   logic known;

   always_comb begin
      known         = 1'b1;
      push_cmd.op   = OP_STATUS;
      push_cmd.data = req_data_in;
      push_cmd.last = req_last_in;
      case (req_mode)
         MODE_WRITE:   push_cmd.op = OP_WRITE;
         MODE_DEQUEUE: push_cmd.op = OP_DEQUEUE;
         MODE_PEEK:    push_cmd.op = OP_PEEK;
         MODE_CLEAR:   push_cmd.op = OP_CLEAR;
         MODE_STATUS:  push_cmd.op = OP_STATUS;
         default:      known       = 1'b0;
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid & known;

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_cmd_queue.sv
// ----------------------------------------------------------------------------
// mrf_cmd_queue
// two-entry command queue between front end and back end
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire mrf_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output mrf_pkg::cmd_type      pop_cmd
);

   import mrf_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// command executor: owns the ring pointers, the byte and length rams and
// the result register, streams the head message, unless rsp stalls, one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_back #(
   parameter int SLOTS   = 8,
   parameter int MAX_LEN = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pop_valid,
   output logic                              pop_ready,
   input  wire mrf_pkg::cmd_type             pop_cmd,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [mrf_pkg::KIND_W-1:0]        rsp_kind,
   output logic [mrf_pkg::DATA_W-1:0]        rsp_data_out,
   output logic                              rsp_last_out,
   output logic [mrf_pkg::HLEN_W-1:0]        rsp_head_length,
   output logic [mrf_pkg::COUNT_W-1:0]       rsp_stored_count,
   output logic                              rsp_truncated
);

   import mrf_pkg::*;

   localparam int PW    = $clog2(SLOTS);
   localparam int DEPTH = SLOTS * MAX_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(MAX_LEN + 2);

   localparam logic [PW-1:0] LAST_PTR  = PW'(SLOTS - 1);
   localparam logic [AW-1:0] LAST_BASE = AW'((SLOTS - 1) * MAX_LEN);
   localparam logic [AW-1:0] LEN_A     = AW'(MAX_LEN);
   localparam logic [FW-1:0] LEN_F     = FW'(MAX_LEN);
   localparam logic [FW-1:0] FILL_SAT  = FW'(MAX_LEN + 1);
   localparam logic [PW:0]   SLOTS_C   = (PW + 1)'(SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_STREAM = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [PW-1:0]     head_ptr_ff, head_ptr_in;
   logic [PW-1:0]     tail_ptr_ff, tail_ptr_in;
   logic [AW-1:0]     head_base_ff, head_base_in;
   logic [AW-1:0]     tail_base_ff, tail_base_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     idx_ff, idx_in;
   logic [HLEN_W-1:0] cur_len_ff, cur_len_in;
   logic              trunc_ff, trunc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [HLEN_W-1:0] rsp_hlen_ff, rsp_hlen_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   logic              byte_we, byte_re;
   logic [AW-1:0]     byte_waddr, byte_raddr;
   logic [DATA_W-1:0] byte_rdata;
   logic [FW-1:0]     rd_idx;
   logic              len_we, len_re;
   logic [HLEN_W-1:0] len_rdata;

   logic              out_free, empty, full, pop, stream_last;
   logic [PW-1:0]     head_next, tail_next;
   logic [AW-1:0]     head_base_next, tail_base_next;
   logic [PW:0]       count;
   logic [COUNT_W-1:0] count_out;
   logic [HLEN_W-1:0] hlen;
   logic [FW-1:0]     fill_inc;

   assign out_free       = ~rsp_valid_ff | rsp_ready;
   assign empty          = (head_ptr_ff == tail_ptr_ff);
   assign head_next      = (head_ptr_ff == LAST_PTR) ? '0 : head_ptr_ff + 1'b1;
   assign tail_next      = (tail_ptr_ff == LAST_PTR) ? '0 : tail_ptr_ff + 1'b1;
   assign head_base_next = (head_base_ff == LAST_BASE) ? '0 : head_base_ff + LEN_A;
   assign tail_base_next = (tail_base_ff == LAST_BASE) ? '0 : tail_base_ff + LEN_A;
   assign full           = (tail_next == head_ptr_ff);
   assign count          = (tail_ptr_ff >= head_ptr_ff)
                         ? ({1'b0, tail_ptr_ff} - {1'b0, head_ptr_ff})
                         : ({1'b0, tail_ptr_ff} + SLOTS_C - {1'b0, head_ptr_ff});
   assign count_out      = COUNT_W'(count);
   assign hlen           = empty ? '0 : len_rdata;
   assign fill_inc       = (fill_ff == FILL_SAT) ? fill_ff : fill_ff + 1'b1;
   assign stream_last    = (HLEN_W'(idx_ff) + 1'b1 == cur_len_ff);
   assign pop_ready      = (state_ff == ST_IDLE);
   assign pop            = pop_valid & pop_ready;

   assign byte_waddr = tail_base_ff + AW'(fill_ff);
   assign byte_raddr = head_base_ff + AW'(rd_idx);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      head_ptr_in  = head_ptr_ff;
      tail_ptr_in  = tail_ptr_ff;
      head_base_in = head_base_ff;
      tail_base_in = tail_base_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      cur_len_in   = cur_len_ff;
      trunc_in     = trunc_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_hlen_in  = rsp_hlen_ff;
      rsp_count_in = rsp_count_ff;
      rsp_trunc_in = rsp_trunc_ff;

      byte_we = 1'b0;
      byte_re = 1'b0;
      rd_idx  = '0;
      len_we  = 1'b0;
      len_re  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               op_in  = pop_cmd.op;
               len_re = 1'b1;
               case (pop_cmd.op)
                  OP_WRITE: begin
                     byte_we = (fill_ff < LEN_F);
                     if (pop_cmd.last) begin
                        trunc_in   = (fill_inc > LEN_F);
                        cur_len_in = (fill_inc > LEN_F) ? HLEN_W'(MAX_LEN)
                                                        : HLEN_W'(fill_inc);
                        fill_in    = '0;
                        state_in   = ST_EXEC;
                     end else begin
                        fill_in = fill_inc;
                     end
                  end
                  OP_DEQUEUE, OP_PEEK, OP_STATUS: begin
                     state_in = ST_EXEC;
                  end
                  OP_CLEAR: begin
                     head_ptr_in  = '0;
                     tail_ptr_in  = '0;
                     head_base_in = '0;
                     tail_base_in = '0;
                     fill_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EXEC: begin
            if ((op_ff == OP_DEQUEUE || op_ff == OP_PEEK) && !empty) begin
               // open the stream: fetch the first byte of the head slot
               byte_re    = 1'b1;
               rd_idx     = '0;
               idx_in     = '0;
               cur_len_in = len_rdata;
               state_in   = ST_STREAM;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_hlen_in  = hlen;
               rsp_count_in = count_out;
               rsp_trunc_in = 1'b0;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_WRITE: begin
                     rsp_trunc_in = trunc_ff;
                     if (full) begin
                        rsp_kind_in = KIND_DROPPED;
                     end else begin
                        rsp_kind_in  = KIND_STORED;
                        len_we       = 1'b1;
                        tail_ptr_in  = tail_next;
                        tail_base_in = tail_base_next;
                     end
                  end
                  OP_DEQUEUE, OP_PEEK: begin
                     rsp_kind_in = KIND_EMPTY;
                  end
                  default: begin
                     rsp_kind_in = KIND_STATUS;
                  end
               endcase
            end
         end

         ST_STREAM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_READ;
               rsp_data_in  = byte_rdata;
               rsp_last_in  = stream_last;
               rsp_hlen_in  = cur_len_ff;
               rsp_count_in = count_out;
               rsp_trunc_in = 1'b0;
               if (stream_last) begin
                  state_in = ST_IDLE;
                  if (op_ff == OP_DEQUEUE) begin
                     head_ptr_in  = head_next;
                     head_base_in = head_base_next;
                  end
               end else begin
                  byte_re = 1'b1;
                  rd_idx  = idx_ff + 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         head_base_ff <= '0;
         tail_base_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         head_base_ff <= head_base_in;
         tail_base_ff <= tail_base_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      cur_len_ff   <= cur_len_in;
      trunc_ff     <= trunc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_hlen_ff  <= rsp_hlen_in;
      rsp_count_ff <= rsp_count_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   mrf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data (pop_cmd.data),
      .rd_en   (byte_re),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   mrf_ram #(
      .WIDTH (HLEN_W),
      .DEPTH (SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (tail_ptr_ff),
      .wr_data (cur_len_ff),
      .rd_en   (len_re),
      .rd_addr (head_ptr_ff),
      .rd_data (len_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_head_length  = rsp_hlen_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_truncated    = rsp_trunc_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_checker
// port level checks of the message ring fifo response channel
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [mrf_pkg::KIND_W-1:0]   rsp_kind,
   input  wire logic [mrf_pkg::DATA_W-1:0]   rsp_data_out,
   input  wire logic                         rsp_last_out,
   input  wire logic [mrf_pkg::HLEN_W-1:0]   rsp_head_length,
   input  wire logic [mrf_pkg::COUNT_W-1:0]  rsp_stored_count,
   input  wire logic                         rsp_truncated
);

   import mrf_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_out) && $stable(rsp_last_out)
         && $stable(rsp_head_length) && $stable(rsp_stored_count))
      else $error("response beat changed while stalled");

   // a read byte comes from a held, non-empty message
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READ |-> rsp_head_length != '0
         && rsp_stored_count != '0 && !rsp_truncated)
      else $error("read beat from an empty ring");

   // every kind but a read byte is a single closing beat
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_READ |-> rsp_last_out && rsp_data_out == '0)
      else $error("single beat result without last");

   // empty reply reports an empty ring
   a_empty_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EMPTY |-> rsp_head_length == '0
         && rsp_stored_count == '0)
      else $error("empty reply with messages held");

endmodule

bind message_ring_fifo mrf_checker u_mrf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_data_out     (rsp_data_out),
   .rsp_last_out     (rsp_last_out),
   .rsp_head_length  (rsp_head_length),
   .rsp_stored_count (rsp_stored_count),
   .rsp_truncated    (rsp_truncated)
);

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the message ring fifo: a short table of directed
// beats, then random message traffic with random gaps on both channels;
// every response beat is compared against a hand-written beat or the in-bench model of the ring
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mrf_pkg::*;

   localparam int SLOTS   = 8;
   localparam int MAX_LEN = 32;

   // modes the block has to ignore
   localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

   localparam int unsigned RANDOM_ITEMS = 250;
   localparam int unsigned TAIL_CYCLES  = 16;
   // worst case ~370 beats x (64 results x longest stall + gaps), taken 4x
   localparam longint unsigned RUN_LIMIT_NS = 64'd40_000_000;

   // one response beat
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  data;
      logic               last;
      logic [HLEN_W-1:0]  hlen;
      logic [COUNT_W-1:0] count;
      logic               trunc;
   } ring_rsp_type;

   // one row of the directed table; reps repeats the beat with data counting up
   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] data;
      logic              last;
      int unsigned       reps;
      bit                typed;
      ring_rsp_type      want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic                req_last_in = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [DATA_W-1:0]   rsp_data_out;
   logic                rsp_last_out;
   logic [HLEN_W-1:0]   rsp_head_length;
   logic [COUNT_W-1:0]  rsp_stored_count;
   logic                rsp_truncated;

   // model of the ring
   logic [DATA_W-1:0]   byte_mem [SLOTS*MAX_LEN];
   logic [HLEN_W-1:0]   len_mem [SLOTS];
   int unsigned         rd_slot = 0;
   int unsigned         wr_slot = 0;
   int unsigned         fill = 0;

   ring_rsp_type        step_rsps[$];     // beats caused by the latest request
   ring_rsp_type        awaited_rsps[$];  // beats still to come out of the block
   dir_row_type         plan[$];

   int unsigned         mismatches = 0;
   int unsigned         items_sent = 0;
   bit                  quiet_run = 1'b0; // no gaps on either side while set
   int unsigned         stall_left = 0;

   always #4 clock = ~clock;

   message_ring_fifo #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_in      (req_data_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_out     (rsp_last_out),
      .rsp_head_length  (rsp_head_length),
      .rsp_stored_count (rsp_stored_count),
      .rsp_truncated    (rsp_truncated)
   );

   // random idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_run) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // advance the ring model by one request and collect the beats it causes
   task automatic ring_predict(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                               input logic last);
      int unsigned  held;
      int unsigned  head_len;
      int unsigned  len;
      int unsigned  i;
      bit           cut;
      ring_rsp_type r;
      held     = (wr_slot + SLOTS - rd_slot) % SLOTS;
      head_len = (rd_slot == wr_slot) ? 0 : len_mem[rd_slot];
      step_rsps.delete();
      case (mode)
         MODE_WRITE: begin
            // bytes past the slot size are dropped, fill saturates one above
            if (fill < MAX_LEN) begin
               byte_mem[wr_slot*MAX_LEN + fill] = data;
            end
            if (fill <= MAX_LEN) begin
               fill++;
            end
            if (last) begin
               cut  = (fill > MAX_LEN);
               len  = cut ? MAX_LEN : fill;
               fill = 0;
               r = '{kind: KIND_STORED, data: '0, last: 1'b1, hlen: head_len[HLEN_W-1:0],
                     count: held[COUNT_W-1:0], trunc: cut};
               // one slot always stays free, so next tail hitting head means full
               if ((wr_slot + 1) % SLOTS == rd_slot) begin
                  r.kind = KIND_DROPPED;
               end else begin
                  len_mem[wr_slot] = len[HLEN_W-1:0];
                  wr_slot = (wr_slot + 1) % SLOTS;
               end
               step_rsps.push_back(r);
            end
         end
         MODE_DEQUEUE, MODE_PEEK: begin
            if (rd_slot == wr_slot) begin
               step_rsps.push_back('{kind: KIND_EMPTY, data: '0, last: 1'b1, hlen: '0,
                                     count: held[COUNT_W-1:0], trunc: 1'b0});
            end else begin
               for (i = 0; i < head_len; i++) begin
                  step_rsps.push_back('{kind: KIND_READ, data: byte_mem[rd_slot*MAX_LEN + i],
                                        last: (i + 1 == head_len), hlen: head_len[HLEN_W-1:0],
                                        count: held[COUNT_W-1:0], trunc: 1'b0});
               end
               if (mode == MODE_DEQUEUE) begin
                  rd_slot = (rd_slot + 1) % SLOTS;
               end
            end
         end
         MODE_CLEAR: begin
            // a half-written message goes away with the pointers
            rd_slot = 0;
            wr_slot = 0;
            fill    = 0;
         end
         MODE_STATUS: begin
            step_rsps.push_back('{kind: KIND_STATUS, data: '0, last: 1'b1,
                                  hlen: head_len[HLEN_W-1:0], count: held[COUNT_W-1:0],
                                  trunc: 1'b0});
         end
         default: begin
            // reserved modes: no beat, no state change
         end
      endcase
   endtask

   // drive one request beat and hold it until accepted; called just after a rising edge
   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                            input logic last, input bit typed, input ring_rsp_type want);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_data_in <= data;
      req_last_in <= last;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      ring_predict(mode, data, last);
      // typed rows carry their own single expected beat
      if (typed) begin
         awaited_rsps.push_back(want);
      end else begin
         foreach (step_rsps[n]) begin
            awaited_rsps.push_back(step_rsps[n]);
         end
      end
      if (mode <= MODE_STATUS) begin
         items_sent++;
      end
   endtask

   // sender holds off until the block has delivered everything owed
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (awaited_rsps.size() != 0);
   endtask

   task automatic add_row(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                          input logic last, input int unsigned reps);
      dir_row_type row;
      row.mode  = mode;
      row.data  = data;
      row.last  = last;
      row.reps  = reps;
      row.typed = 1'b0;
      row.want  = '0;
      plan.push_back(row);
   endtask

   // single-beat row whose only response is written out by hand
   task automatic add_typed(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                            input logic last, input logic [KIND_W-1:0] kind,
                            input int unsigned hlen, input int unsigned count);
      dir_row_type row;
      row.mode  = mode;
      row.data  = data;
      row.last  = last;
      row.reps  = 1;
      row.typed = 1'b1;
      row.want  = '{kind: kind, data: '0, last: 1'b1, hlen: hlen[HLEN_W-1:0],
                    count: count[COUNT_W-1:0], trunc: 1'b0};
      plan.push_back(row);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // response side: compare each accepted beat with the oldest one awaited,
   // then pick the next ready level
   always @(posedge clock) begin : rsp_side
      ring_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsps.size() == 0) begin
            $error("unexpected response beat: kind %0d data %0d", rsp_kind, rsp_data_out);
            mismatches++;
         end else begin
            want = awaited_rsps.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("data_out", want.data, rsp_data_out);
            check_field("last_out", want.last, rsp_last_out);
            check_field("head_length", want.hlen, rsp_head_length);
            check_field("stored_count", want.count, rsp_stored_count);
            check_field("truncated", want.trunc, rsp_truncated);
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   initial begin : stimulus
      int unsigned start_count;
      int unsigned roll;
      int unsigned msg_len;
      int unsigned k;

      // directed table
      add_typed(MODE_STATUS,  8'h00, 1'b1, KIND_STATUS, 0, 0);   // fresh out of reset
      add_typed(MODE_DEQUEUE, 8'h00, 1'b1, KIND_EMPTY, 0, 0);    // dequeue on empty ring
      add_typed(MODE_PEEK,    8'h00, 1'b1, KIND_EMPTY, 0, 0);    // peek on empty ring
      add_typed(MODE_WRITE,   8'h00, 1'b1, KIND_STORED, 0, 0);   // one-byte message
      add_row(MODE_WRITE, 8'hff, 1'b0, MAX_LEN + 1);             // overlong message
      add_row(MODE_WRITE, 8'h80, 1'b1, 1);                       // commit, gets cut
      add_row(MODE_WRITE, 8'h10, 1'b0, MAX_LEN - 1);             // exactly slot sized
      add_row(MODE_WRITE, 8'h7f, 1'b1, 1);
      add_typed(MODE_STATUS,  8'hff, 1'b0, KIND_STATUS, 1, 3);
      add_row(MODE_PEEK,    8'h00, 1'b0, 1);
      add_row(MODE_DEQUEUE, 8'h00, 1'b1, 1);
      add_row(MODE_PEEK,    8'hff, 1'b1, 1);
      add_row(MODE_DEQUEUE, 8'hff, 1'b0, 1);
      add_row(MODE_WRITE, 8'h5a, 1'b1, SLOTS - 2);               // fill up the ring
      add_row(MODE_WRITE, 8'hc3, 1'b0, 2);
      add_row(MODE_WRITE, 8'h3c, 1'b1, 1);                       // commit while full
      add_row(MODE_WRITE, 8'h01, 1'b1, 1);                       // and again
      add_typed(MODE_STATUS,  8'h00, 1'b1, KIND_STATUS, MAX_LEN, SLOTS - 1);
      add_row(MODE_RSVD_LO, 8'haa, 1'b1, 1);                     // reserved modes
      add_row(MODE_RSVD_LO + 3'd1, 8'h55, 1'b0, 1);
      add_row(MODE_RSVD_HI, 8'hff, 1'b1, 1);
      add_row(MODE_DEQUEUE, 8'h00, 1'b1, 1);                     // longest read
      add_row(MODE_WRITE, 8'h44, 1'b0, 3);                       // half a message
      add_row(MODE_CLEAR, 8'hff, 1'b1, 1);                       // clear drops it
      add_typed(MODE_STATUS,  8'h00, 1'b0, KIND_STATUS, 0, 0);
      add_typed(MODE_DEQUEUE, 8'h00, 1'b0, KIND_EMPTY, 0, 0);
      add_typed(MODE_WRITE,   8'h99, 1'b1, KIND_STORED, 0, 0);
      add_row(MODE_DEQUEUE, 8'h00, 1'b0, 1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (k = 0; k < plan[r].reps; k++) begin
            send_beat(plan[r].mode, plan[r].data + k[DATA_W-1:0], plan[r].last,
                      plan[r].typed, plan[r].want);
         end
      end
      // hold off once until the block is empty
      wait_drained();

      // random traffic: mostly whole messages and reads, some noise
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 4) begin
            quiet_run = !quiet_run;
         end
         roll = $urandom_range(0, 99);
         if (roll < 42) begin
            // whole message, now and then around the slot size, up to three past it
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 3)
                                                  : $urandom_range(1, 6);
            for (k = 0; k < msg_len; k++) begin
               send_beat(MODE_WRITE, DATA_W'($urandom), k + 1 == msg_len, 1'b0, '0);
            end
         end else if (roll < 66) begin
            send_beat(MODE_DEQUEUE, DATA_W'($urandom), 1'($urandom), 1'b0, '0);
         end else if (roll < 74) begin
            send_beat(MODE_PEEK, DATA_W'($urandom), 1'($urandom), 1'b0, '0);
         end else if (roll < 82) begin
            send_beat(MODE_STATUS, DATA_W'($urandom), 1'($urandom), 1'b0, '0);
         end else if (roll < 85) begin
            send_beat(MODE_CLEAR, DATA_W'($urandom), 1'($urandom), 1'b0, '0);
         end else if (roll < 92) begin
            // broken message: a few bytes with no last, sometimes cut by a clear
            msg_len = $urandom_range(1, 4);
            for (k = 0; k < msg_len; k++) begin
               send_beat(MODE_WRITE, DATA_W'($urandom), 1'b0, 1'b0, '0);
            end
            if ($urandom_range(0, 1) == 0) begin
               send_beat(MODE_CLEAR, DATA_W'($urandom), 1'($urandom), 1'b0, '0);
            end
         end else if (roll < 97) begin
            send_beat(MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), DATA_W'($urandom),
                      1'($urandom), 1'b0, '0);
         end else begin
            wait_drained();
         end
      end

      // let the last beats come out, then a quiet tail for strays
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_ram.sv
hw/rtl/mrf_front.sv
hw/rtl/mrf_cmd_queue.sv
hw/rtl/mrf_back.sv
hw/rtl/message_ring_fifo.sv
hw/rtl/mrf_checker.sv
verif/tb_top.sv
